[design/bobcs_pkg.sv]
// Shared types and constants of the bulk-only block command sequencer.
`timescale 1ns / 1ps

package bobcs_pkg;

    localparam int STAGE_SECTORS = 8;
    localparam int SECTOR_BYTES  = 512;

    localparam logic [31:0] SIG_STATUS = 32'h53425355;
    localparam logic [7:0]  OP_READ10  = 8'h28;
    localparam logic [7:0]  OP_WRITE10 = 8'h2A;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_STATUS = 2'd2;

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_FAIL   = 2'd2;
    localparam logic [1:0] KIND_IGNORE = 2'd3;

    // Bit counts of the two divider runs.
    localparam logic [6:0] CHUNK_STEPS  = 7'd4;
    localparam logic [6:0] SECTOR_STEPS = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_DIV_CHUNK,
        ST_DIV_SECT,
        ST_FINISH
    } state_t;

endpackage

[design/bulk_only_block_command_sequencer.sv]
// Top level of the bulk-only block command sequencer.
// Flow: ignored items, empty or finished requests and bad status go from idle straight to the
// output stage; a zero block size fails after planning; an item that plans a chunk passes through
// planning, 4 chunk and 64 sector steps of the one-bit-per-cycle divider and output, plus any wait.
// Throughput: one item at a time; s_tready is high only while the sequencer idles.
// Reset: rst_n clears all control state asynchronously; the block size register resets to 1.
`timescale 1ns / 1ps

module bulk_only_block_command_sequencer
    import bobcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,     // block size in sectors
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_sector[63:0], sector_count[95:64], status_signature[127:96],
    // status_tag[159:128], status_code[167:160], transport_failed[168], zero pad
    input  logic [175:0] s_tdata,
    input  logic [1:0]   s_tuser,      // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    // command_tag[31:0], scsi_opcode[39:32], block_address[71:40], block_count[75:72],
    // transfer_bytes[88:76], direction_in[89], zero pad
    output logic [95:0]  m_tdata,
    output logic [1:0]   m_tuser       // result_kind
);

    state_t state_reg, state_next;

    logic [7:0]  spb_reg;
    logic        busy_reg, busy_next;
    logic        is_write_reg, is_write_next;
    logic [63:0] cur_reg, cur_next;
    logic [31:0] left_reg, left_next;
    logic [3:0]  chunk_reg, chunk_next;
    logic [31:0] exp_tag_reg, exp_tag_next;
    logic [31:0] tag_cnt_reg, tag_cnt_next;
    logic [1:0]  res_kind_reg, res_kind_next;

    // Shared divider: dividend/quotient shift register, remainder and step count.
    logic [63:0] div_reg, div_next;
    logic [7:0]  rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [3:0]  trim_reg, trim_next;
    logic [3:0]  qcnt_reg, qcnt_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] o_tag_reg, o_tag_next;
    logic [7:0]  o_op_reg, o_op_next;
    logic [31:0] o_addr_reg, o_addr_next;
    logic [3:0]  o_cnt_reg, o_cnt_next;
    logic [12:0] o_bytes_reg, o_bytes_next;
    logic        o_dir_reg, o_dir_next;

    logic [63:0] in_start;
    logic [31:0] in_count;
    logic [31:0] in_sig;
    logic [31:0] in_tag;
    logic [7:0]  in_code;
    logic        in_tfail;
    logic        accept;
    logic        status_ok;
    logic [8:0]  rem_shift;
    logic        rem_ge;
    logic [7:0]  rem_step;
    logic [3:0]  chunk_raw;
    logic [3:0]  trim_val;
    logic        out_free;
    logic        div_last;

    assign in_start = s_tdata[63:0];
    assign in_count = s_tdata[95:64];
    assign in_sig   = s_tdata[127:96];
    assign in_tag   = s_tdata[159:128];
    assign in_code  = s_tdata[167:160];
    assign in_tfail = s_tdata[168];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign div_last = (cnt_reg == 7'd1);

    assign status_ok = !in_tfail && (in_sig == SIG_STATUS) && (in_tag == exp_tag_reg)
                       && (in_code == 8'd0);

    // One restoring division step.
    assign rem_shift = {rem_reg, div_reg[63]};
    assign rem_ge    = (rem_shift >= {1'b0, spb_reg});
    assign rem_step  = rem_ge ? 8'(rem_shift - {1'b0, spb_reg}) : rem_shift[7:0];

    assign chunk_raw = (left_reg > 32'(STAGE_SECTORS)) ? 4'(STAGE_SECTORS) : left_reg[3:0];
    assign trim_val  = 4'(chunk_reg - rem_step[3:0]);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((s_tuser == REQ_READ || s_tuser == REQ_WRITE) && !busy_reg
                        && in_count != 32'd0)
                        state_next = ST_PLAN;
                    else if (s_tuser == REQ_STATUS && busy_reg && status_ok
                             && left_reg != 32'(chunk_reg))
                        state_next = ST_PLAN;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_PLAN:
            begin
                if (spb_reg == 8'd0)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIV_CHUNK;
            end
            ST_DIV_CHUNK:
            begin
                if (div_last)
                    state_next = ST_DIV_SECT;
            end
            ST_DIV_SECT:
            begin
                if (div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result register.
    always_comb
    begin
        busy_next     = busy_reg;
        is_write_next = is_write_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        chunk_next    = chunk_reg;
        exp_tag_next  = exp_tag_reg;
        tag_cnt_next  = tag_cnt_reg;
        res_kind_next = res_kind_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        trim_next     = trim_reg;
        qcnt_next     = qcnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        kind_next     = kind_reg;
        o_tag_next    = o_tag_reg;
        o_op_next     = o_op_reg;
        o_addr_next   = o_addr_reg;
        o_cnt_next    = o_cnt_reg;
        o_bytes_next  = o_bytes_reg;
        o_dir_next    = o_dir_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_kind_next = KIND_IGNORE;
                    if ((s_tuser == REQ_READ || s_tuser == REQ_WRITE) && !busy_reg)
                    begin
                        is_write_next = (s_tuser == REQ_WRITE);
                        cur_next      = in_start;
                        left_next     = in_count;
                        chunk_next    = 4'd0;
                        if (in_count == 32'd0)
                            res_kind_next = KIND_DONE;
                        else
                            busy_next = 1'b1;
                    end
                    else if (s_tuser == REQ_STATUS && busy_reg)
                    begin
                        if (!status_ok)
                        begin
                            busy_next     = 1'b0;
                            res_kind_next = KIND_FAIL;
                        end
                        else
                        begin
                            cur_next  = cur_reg + 64'(chunk_reg);
                            left_next = left_reg - 32'(chunk_reg);
                            if (left_reg == 32'(chunk_reg))
                            begin
                                busy_next     = 1'b0;
                                res_kind_next = KIND_DONE;
                            end
                        end
                    end
                end
            end
            ST_PLAN:
            begin
                if (spb_reg == 8'd0)
                begin
                    busy_next     = 1'b0;
                    res_kind_next = KIND_FAIL;
                end
                // The chunk register holds the untrimmed chunk during the divide.
                chunk_next = chunk_raw;
                div_next   = {chunk_raw, 60'd0};
                rem_next   = 8'd0;
                cnt_next   = CHUNK_STEPS;
            end
            ST_DIV_CHUNK:
            begin
                div_next = {div_reg[62:0], rem_ge};
                rem_next = rem_step;
                cnt_next = cnt_reg - 7'd1;
                if (div_last)
                begin
                    trim_next = trim_val;
                    qcnt_next = {div_reg[2:0], rem_ge};
                    div_next  = cur_reg;
                    rem_next  = 8'd0;
                    cnt_next  = SECTOR_STEPS;
                end
            end
            ST_DIV_SECT:
            begin
                div_next = {div_reg[62:0], rem_ge};
                rem_next = rem_step;
                cnt_next = cnt_reg - 7'd1;
                if (div_last)
                begin
                    if (trim_reg == 4'd0 || rem_step != 8'd0)
                    begin
                        busy_next     = 1'b0;
                        res_kind_next = KIND_FAIL;
                    end
                    else
                    begin
                        chunk_next    = trim_reg;
                        exp_tag_next  = tag_cnt_reg;
                        tag_cnt_next  = tag_cnt_reg + 32'd1;
                        res_kind_next = KIND_CMD;
                    end
                end
            end
            ST_FINISH:
            begin
                // The quotient stays in the divider register until the result is loaded.
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    kind_next    = res_kind_reg;
                    if (res_kind_reg == KIND_CMD)
                    begin
                        o_tag_next   = exp_tag_reg;
                        o_op_next    = is_write_reg ? OP_WRITE10 : OP_READ10;
                        o_addr_next  = div_reg[31:0];
                        o_cnt_next   = qcnt_reg;
                        o_bytes_next = 13'(32'(chunk_reg) * SECTOR_BYTES);
                        o_dir_next   = !is_write_reg;
                    end
                    else
                    begin
                        o_tag_next   = 32'd0;
                        o_op_next    = 8'd0;
                        o_addr_next  = 32'd0;
                        o_cnt_next   = 4'd0;
                        o_bytes_next = 13'd0;
                        o_dir_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cfg_ready = 1'b1;
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = m_valid_reg;
        m_tuser   = kind_reg;
        m_tdata   = {6'd0, o_dir_reg, o_bytes_reg, o_cnt_reg, o_addr_reg, o_op_reg, o_tag_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            spb_reg      <= 8'd1;
            busy_reg     <= 1'b0;
            is_write_reg <= 1'b0;
            cur_reg      <= 64'd0;
            left_reg     <= 32'd0;
            chunk_reg    <= 4'd0;
            exp_tag_reg  <= 32'd0;
            tag_cnt_reg  <= 32'd1;
            res_kind_reg <= KIND_IGNORE;
            cnt_reg      <= 7'd0;
            m_valid_reg  <= 1'b0;
            kind_reg     <= KIND_IGNORE;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready)
                spb_reg  <= cfg_data;
            busy_reg     <= busy_next;
            is_write_reg <= is_write_next;
            cur_reg      <= cur_next;
            left_reg     <= left_next;
            chunk_reg    <= chunk_next;
            exp_tag_reg  <= exp_tag_next;
            tag_cnt_reg  <= tag_cnt_next;
            res_kind_reg <= res_kind_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            kind_reg     <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        trim_reg    <= trim_next;
        qcnt_reg    <= qcnt_next;
        o_tag_reg   <= o_tag_next;
        o_op_reg    <= o_op_next;
        o_addr_reg  <= o_addr_next;
        o_cnt_reg   <= o_cnt_next;
        o_bytes_reg <= o_bytes_next;
        o_dir_reg   <= o_dir_next;
    end

`ifndef SYNTHESIS
    // A command always moves at least one block.
    a_cmd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_CMD) |-> (m_tdata[75:72] != 4'd0 && m_tdata[88:76] != 13'd0))
        else $error("command result with zero block count");

    // Without a running request the sequencer never sits in the divider.
    a_idle_not_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (state_reg == ST_IDLE || state_reg == ST_FINISH))
        else $error("divider active with no request running");

    // An accepted transfer always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted transfer did not start work");
`endif

endmodule
